// ===== design/nearest_k_point_select_assert.svh =====
// Assertion macros for the nearest_k_point_select block.
// Included by the top level; no other dependencies.
`ifndef NEAREST_K_POINT_SELECT_ASSERT_SVH
`define NEAREST_K_POINT_SELECT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define NKPS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NKPS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define NKPS_ASSERT(label, clk, rst_n, prop, msg)
`define NKPS_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== design/nkps_pkg.sv =====
// Package for nearest_k_point_select: sizes, codes and shared types.
// No dependencies.
`default_nettype none
package nkps_pkg;
  localparam int TableDepth = 64;
  localparam int MaxSlots   = 16;
  localparam int RowW  = $clog2(TableDepth);
  localparam int CntW  = $clog2(TableDepth + 1);
  localparam int SlotW = $clog2(MaxSlots);
  localparam int SelW  = $clog2(MaxSlots + 1);
  localparam int CmdQDepth = 2;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0, OP_REMOVE = 2'd1, OP_CLEAR = 2'd2, OP_SELECT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_DUP = 2'd1, ST_FULL = 2'd2, ST_NOT_FOUND = 2'd3
  } status_e;

  // Item passed from front to back end
  typedef struct packed {
    op_e                op;
    logic [15:0]        entry_id;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [SelW-1:0]    n_sel;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    logic        slot_valid;
    logic [15:0] slot_id;
    logic [33:0] distance_sq;
    logic [3:0]  rank;
    logic        last;
  } res_t;
endpackage
`default_nettype wire

// ===== design/nkps_front.sv =====
// Front end: accepts items, latches the slot count, queues commands.
// Depends on nkps_pkg.
`default_nettype none
module nkps_front import nkps_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  output logic             full_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [15:0] entry_id_i,
  input  wire logic [15:0] pos_x_i,
  input  wire logic [15:0] pos_y_i,
  input  wire logic [15:0] pos_z_i,
  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_wdata_i,
  output logic             cmd_valid_o,
  output cmd_t             cmd_o,
  input  wire logic        cmd_take_i
);
  localparam int PtrW = $clog2(CmdQDepth);
  logic [4:0]   max_sel_q;
  logic [SelW-1:0] n_sel;
  cmd_t         q_mem [CmdQDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;
  logic         do_push, do_pop;

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_sel_q <= 5'd16;
    end else if (cfg_we_i) begin
      max_sel_q <= cfg_wdata_i;
    end
  end

  // Clamp slot count to 1..MaxSlots
  always_comb begin
    if (max_sel_q == 5'd0) begin
      n_sel = SelW'(1);
    end else if (32'(max_sel_q) > MaxSlots) begin
      n_sel = SelW'(MaxSlots);
    end else begin
      n_sel = SelW'(max_sel_q);
    end
  end

  assign full_o      = (cnt_q == (PtrW+1)'(CmdQDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rp_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_take_i && cmd_valid_o;

  // Command queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= wp_q + 1'b1;
      end
      if (do_pop) begin
        rp_q <= rp_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wp_q] <= '{op: op_e'(op_i), entry_id: entry_id_i, pos_x: pos_x_i,
                       pos_y: pos_y_i, pos_z: pos_z_i, n_sel: n_sel};
    end
  end
endmodule
`default_nettype wire

// ===== design/nkps_back.sv =====
// Back end: point table, row scan with distance pipeline, sorted list, emit.
// Depends on nkps_pkg.
`default_nettype none
module nkps_back import nkps_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_take_o,
  output logic      res_valid_o,
  output res_t      res_o,
  input  wire logic res_take_i
);
  typedef enum logic [2:0] {
    S_IDLE, S_FIND, S_RESOLVE, S_SCAN, S_DRAIN, S_EMIT
  } state_e;

  state_e state_q;
  cmd_t   cmd_q;
  logic [TableDepth-1:0] used_q, used_d;
  logic [15:0] ident_mem [TableDepth];
  logic [47:0] pos_mem   [TableDepth];

  logic [CntW-1:0] scan_q;
  logic [SlotW-1:0] emit_q;
  logic [MaxSlots-1:0] bvalid_q;
  logic [33:0] bdist_q [MaxSlots];
  logic [15:0] bid_q   [MaxSlots];

  // Pipeline: row read -> diffs/squares -> sum -> insert
  logic        p1_v_q, p2_v_q, p3_v_q;
  logic [15:0] p1_id_q, p2_id_q, p3_id_q;
  logic [RowW-1:0] p1_row_q;
  logic [47:0] p1_pos_q;
  logic [31:0] p2_sx_q, p2_sy_q, p2_sz_q;
  logic [33:0] p3_d_q;

  // Id search result for add and remove
  logic            found_q;
  logic [RowW-1:0] found_row_q;
  logic            id_match;

  logic        res_v_q;
  res_t        res_q, res_d;
  logic        res_load;

  // Lowest free row
  logic [RowW-1:0] free_row;
  logic            has_free;
  always_comb begin
    has_free = 1'b0; free_row = '0;
    for (int i = TableDepth - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        has_free = 1'b1; free_row = RowW'(i);
      end
    end
  end

  assign id_match = p1_v_q && (p1_id_q == cmd_q.entry_id) &&
                    (state_q == S_FIND || state_q == S_RESOLVE);

  // Squared differences
  logic signed [16:0] dx, dy, dz;
  assign dx = 17'(signed'(cmd_q.pos_x)) - 17'(signed'(p1_pos_q[15:0]));
  assign dy = 17'(signed'(cmd_q.pos_y)) - 17'(signed'(p1_pos_q[31:16]));
  assign dz = 17'(signed'(cmd_q.pos_z)) - 17'(signed'(p1_pos_q[47:32]));

  // Insert position of the new candidate in the sorted list
  logic [MaxSlots-1:0] before_v;
  always_comb begin
    for (int j = 0; j < MaxSlots; j++) begin
      before_v[j] = !bvalid_q[j] || (p3_d_q < bdist_q[j]) ||
                    (p3_d_q == bdist_q[j] && p3_id_q < bid_q[j]);
    end
  end

  logic ins_ok, ins_go;
  assign ins_ok = before_v[SlotW'(cmd_q.n_sel - 1'b1)];
  assign ins_go = p3_v_q && ins_ok;

  logic out_free;
  assign out_free    = !res_v_q || res_take_i;
  assign res_valid_o = res_v_q;
  assign res_o       = res_q;
  assign cmd_take_o  = (state_q == S_IDLE) && cmd_valid_i && out_free;

  logic resolve_go, emit_go, emit_last, add_store;
  assign resolve_go = (state_q == S_RESOLVE) && !p1_v_q && out_free;
  assign emit_go    = (state_q == S_EMIT) && out_free;
  assign emit_last  = (SelW'(emit_q) == cmd_q.n_sel - 1'b1);
  assign add_store  = resolve_go && cmd_q.op == OP_ADD && !found_q && has_free;

  // Next table state and next result
  always_comb begin
    used_d   = used_q;
    res_load = 1'b0;
    res_d    = '{status: ST_OK, slot_valid: 1'b0, slot_id: '0,
                 distance_sq: '0, rank: '0, last: 1'b1};
    if (cmd_take_o && cmd_i.op == OP_CLEAR) begin
      used_d   = '0;
      res_load = 1'b1;
    end else if (resolve_go) begin
      res_load = 1'b1;
      if (cmd_q.op == OP_ADD) begin
        // duplicate check comes before the full check
        if (found_q) begin
          res_d.status = ST_DUP;
        end else if (!has_free) begin
          res_d.status = ST_FULL;
        end else begin
          used_d[free_row] = 1'b1;
        end
      end else begin
        if (found_q) begin
          used_d[found_row_q] = 1'b0;
        end else begin
          res_d.status = ST_NOT_FOUND;
        end
      end
    end else if (emit_go) begin
      res_load          = 1'b1;
      res_d.slot_valid  = bvalid_q[emit_q];
      res_d.slot_id     = bvalid_q[emit_q] ? bid_q[emit_q] : 16'd0;
      res_d.distance_sq = bvalid_q[emit_q] ? bdist_q[emit_q] : 34'd0;
      res_d.rank        = 4'(emit_q);
      res_d.last        = emit_last;
    end
  end

  // Sequencer and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      used_q   <= '0;
      res_v_q  <= 1'b0;
      bvalid_q <= '0;
      found_q  <= 1'b0;
      p1_v_q <= 1'b0; p2_v_q <= 1'b0; p3_v_q <= 1'b0;
      scan_q <= '0; emit_q <= '0;
    end else begin
      used_q <= used_d;
      p1_v_q <= (state_q == S_FIND || state_q == S_SCAN) && used_q[scan_q[RowW-1:0]];
      p2_v_q <= p1_v_q && (cmd_q.op == OP_SELECT);
      p3_v_q <= p2_v_q;
      if (res_load) begin
        res_v_q <= 1'b1;
      end else if (res_take_i) begin
        res_v_q <= 1'b0;
      end
      if (cmd_take_o) begin
        found_q <= 1'b0;
      end else if (id_match) begin
        found_q <= 1'b1;
      end
      // Candidate insertion; the list is emptied when a select starts
      if (cmd_take_o && cmd_i.op == OP_SELECT) begin
        bvalid_q <= '0;
      end else if (ins_go) begin
        for (int j = 0; j < MaxSlots; j++) begin
          if (before_v[j]) begin
            if (j == 0 || !before_v[j-1]) begin
              bvalid_q[j] <= 1'b1;
            end else begin
              bvalid_q[j] <= bvalid_q[j-1];
            end
          end
        end
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_take_o) begin
            scan_q <= '0;
            unique case (cmd_i.op)
              OP_ADD, OP_REMOVE: state_q <= S_FIND;
              OP_SELECT:         state_q <= S_SCAN;
              OP_CLEAR:          state_q <= S_IDLE;
            endcase
          end
        end
        S_FIND, S_SCAN: begin
          scan_q <= scan_q + 1'b1;
          if (scan_q == CntW'(TableDepth - 1)) begin
            state_q <= (state_q == S_FIND) ? S_RESOLVE : S_DRAIN;
          end
        end
        S_RESOLVE: begin
          if (resolve_go) begin
            state_q <= S_IDLE;
          end
        end
        S_DRAIN: begin
          if (!p1_v_q && !p2_v_q && !p3_v_q) begin
            state_q <= S_EMIT;
            emit_q  <= '0;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            emit_q <= emit_q + 1'b1;
            if (emit_last) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Payload registers, table storage, scan pipeline and sorted list
  always_ff @(posedge clk_i) begin
    if (cmd_take_o) begin
      cmd_q <= cmd_i;
    end
    if (res_load) begin
      res_q <= res_d;
    end
    if (id_match) begin
      found_row_q <= p1_row_q;
    end
    if (add_store) begin
      ident_mem[free_row] <= cmd_q.entry_id;
      pos_mem[free_row]   <= {cmd_q.pos_z, cmd_q.pos_y, cmd_q.pos_x};
    end
    p1_id_q  <= ident_mem[scan_q[RowW-1:0]];
    p1_pos_q <= pos_mem[scan_q[RowW-1:0]];
    p1_row_q <= scan_q[RowW-1:0];
    p2_id_q  <= p1_id_q;
    p2_sx_q  <= 32'(dx * dx);
    p2_sy_q  <= 32'(dy * dy);
    p2_sz_q  <= 32'(dz * dz);
    p3_id_q  <= p2_id_q;
    p3_d_q   <= 34'(p2_sx_q) + 34'(p2_sy_q) + 34'(p2_sz_q);
    if (ins_go) begin
      for (int j = 0; j < MaxSlots; j++) begin
        if (before_v[j]) begin
          if (j == 0 || !before_v[j-1]) begin
            bdist_q[j] <= p3_d_q;
            bid_q[j]   <= p3_id_q;
          end else begin
            bdist_q[j] <= bdist_q[j-1];
            bid_q[j]   <= bid_q[j-1];
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/nearest_k_point_select.sv =====
// Channel   Dir  Handshake       Payload
// items     in   push/full       op, entry_id, pos_x/y/z
// results   out  pop/empty       status, slot_valid, slot_id, distance_sq, rank, last
// config    in   cfg_we_i        cfg_wdata_i (max_selected)
// Add and remove search all 64 rows one per cycle. Clear empties the table and
// loads its result when it is taken. Select scans all 64 rows through a
// 3-stage distance pipe, then emits n slots one per cycle while the output is free.
// A two-deep command queue lets items enter while the back end works; a
// waiting result stalls the back end until it is popped.
// Reset (async, active low) empties the table; no clearing pass.
// Depends on nkps_pkg, nkps_front, nkps_back and the assertion header.
`default_nettype none
`include "nearest_k_point_select_assert.svh"
module nearest_k_point_select import nkps_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  op_i,
  input  wire logic [15:0] entry_id_i,
  input  wire logic [15:0] pos_x_i,
  input  wire logic [15:0] pos_y_i,
  input  wire logic [15:0] pos_z_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       status_o,
  output logic             slot_valid_o,
  output logic [15:0]      slot_id_o,
  output logic [33:0]      distance_sq_o,
  output logic [3:0]       rank_o,
  output logic             last_o,
  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_wdata_i
);
  logic cmd_valid, cmd_take, res_valid;
  cmd_t cmd;
  res_t res;

  nkps_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .op_i, .entry_id_i,
    .pos_x_i, .pos_y_i, .pos_z_i, .cfg_we_i, .cfg_wdata_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_take_i(cmd_take)
  );

  nkps_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_take_o(cmd_take),
    .res_valid_o(res_valid), .res_o(res), .res_take_i(pop)
  );

  assign empty         = !res_valid;
  assign status_o      = res.status;
  assign slot_valid_o  = res.slot_valid;
  assign slot_id_o     = res.slot_id;
  assign distance_sq_o = res.distance_sq;
  assign rank_o        = res.rank;
  assign last_o        = res.last;

  `NKPS_ASSERT(a_pad_zero, clk_i, rst_ni, (!empty && !slot_valid_o) |-> (slot_id_o == 16'd0 && distance_sq_o == 34'd0), "padding slot not zero")
  `NKPS_ASSERT(a_hold, clk_i, rst_ni, (!empty && !pop) |=> (!empty && $stable(rank_o)), "result dropped while stalled")
  `NKPS_ASSERT_NEVER(a_valid_status, clk_i, rst_ni, !empty && slot_valid_o && status_o != ST_OK, "select slot with bad status")
endmodule
`default_nettype wire
